/* design/pose_window_averager_unit_defines.svh */
// Assertion macros for the pose window averager unit.
`ifndef POSE_WINDOW_AVERAGER_UNIT_DEFINES_SVH
`define POSE_WINDOW_AVERAGER_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define PWA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define PWA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error(msg);

`endif

/* design/pwa_pkg.sv */
// Package with the constants and field layout of the pose window averager.
package pwa_pkg;

    localparam int DEPTH   = 8;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = IDX_W + 1;
    localparam int THR_W   = 31;
    localparam int WS_W    = 4;
    localparam int CFG_W   = 31;
    localparam int POS_W   = 32;
    localparam int QC_W    = 16;
    localparam int S_DATA_W = 160;
    localparam int M_DATA_W = 168;

    localparam logic [THR_W-1:0] THR_RESET   = 31'd6554;
    localparam logic [WS_W-1:0]  WSIZE_RESET = 4'd8;

    typedef enum logic {
        REG_JUMP_THRESHOLD = 1'b0,
        REG_WINDOW_SIZE    = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        FUNC_ADD   = 1'b0,
        FUNC_CLEAR = 1'b1
    } func_t;

endpackage

/* design/pose_window_averager_unit.sv */
// Top level of the pose window averager: window memories, jump test, averaging.
// Each request is handled on its own: an add runs the jump test (skipped on an empty window),
// the push and the memory walk, then the position divisions and the quaternion norm, then
// a quotient and a square root for each quaternion component; a clear goes straight to the
// final step, and a zero quaternion sum skips the component stage. The dividers are
// sequential and the square root is bit-serial.
// A finished result waits in an output register while the next request is taken.
`include "pose_window_averager_unit_defines.svh"

module pose_window_averager_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [pwa_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w
    input  logic [pwa_pkg::S_DATA_W-1:0]  s_tdata,
    // func
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // entry_count, window_full, jump_reset, avg_pos_x, avg_pos_y, avg_pos_z,
    // avg_quat_x, avg_quat_y, avg_quat_z, avg_quat_w, zero padding
    output logic [pwa_pkg::M_DATA_W-1:0]  m_tdata
);
    import pwa_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE = 14'b00000000000001,
        ST_JRD  = 14'b00000000000010,
        ST_JCHK = 14'b00000000000100,
        ST_JMUL = 14'b00000000001000,
        ST_PUSH = 14'b00000000010000,
        ST_WRD  = 14'b00000000100000,
        ST_WLAT = 14'b00000001000000,
        ST_WACC = 14'b00000010000000,
        ST_PDIV = 14'b00000100000000,
        ST_NSQ  = 14'b00001000000000,
        ST_QDIV = 14'b00010000000000,
        ST_SQRT = 14'b00100000000000,
        ST_QOUT = 14'b01000000000000,
        ST_FIN  = 14'b10000000000000
    } state_t;

    state_t state_reg;

    logic [THR_W-1:0] thr_reg;
    logic [WS_W-1:0]  wsize_reg;
    logic [CNT_W-1:0] win_reg;
    logic [CNT_W-1:0] held_reg;
    logic [IDX_W-1:0] oldest_reg;
    logic             jump_reg;

    logic [3*POS_W-1:0] in_pos_reg;
    logic [4*QC_W-1:0]  in_quat_reg;

    logic [3*POS_W-1:0] pos_mem [DEPTH];
    logic [4*QC_W-1:0]  quat_mem [DEPTH];
    logic [3*POS_W-1:0] rd_pos_reg;
    logic [4*QC_W-1:0]  rd_quat_reg;
    logic [IDX_W-1:0]   rd_addr;

    logic [POS_W:0]   d_reg [3];
    logic [63:0]      dsum_reg;
    logic [1:0]       mcnt_reg;

    logic [CNT_W-1:0]        k_reg;
    logic signed [QC_W-1:0]  ref_reg [4];
    logic signed [QC_W-1:0]  c_reg [4];
    logic signed [31:0]      prod_reg [4];
    logic [3*POS_W-1:0]      wpos_reg;
    logic signed [35:0]      sp_reg [3];
    logic signed [19:0]      sq_reg [4];

    logic [34:0]       num_reg [3];
    logic [3:0]        rem_reg [3];
    logic              psign_reg [3];
    logic [5:0]        cnt_reg;

    logic [38:0]       n_reg;
    logic [36:0]       sq2_reg [4];
    logic [38:0]       r_reg;
    logic [32:0]       quo_reg;
    logic [33:0]       x_reg;
    logic [33:0]       res_reg;
    logic [33:0]       bit_reg;
    logic [1:0]        j_reg;

    logic [POS_W-1:0]  ap_reg [3];
    logic [QC_W-1:0]   aq_reg [4];

    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    // Push arithmetic
    logic [CNT_W-1:0] ph0, ph1;
    logic [IDX_W-1:0] po0, po1, push_addr;
    logic [CNT_W-1:0] eff_win;

    always_comb begin
        if (wsize_reg == '0) begin
            eff_win = CNT_W'(1);
        end else if (CNT_W'(wsize_reg) > CNT_W'(DEPTH)) begin
            eff_win = CNT_W'(DEPTH);
        end else begin
            eff_win = CNT_W'(wsize_reg);
        end
    end

    always_comb begin
        ph0 = held_reg;
        po0 = oldest_reg;
        if (held_reg >= CNT_W'(DEPTH)) begin
            ph0 = held_reg - CNT_W'(1);
            po0 = oldest_reg + IDX_W'(1);
        end
        push_addr = po0 + ph0[IDX_W-1:0];
        ph1 = ph0 + CNT_W'(1);
        po1 = po0;
        if (ph1 > win_reg) begin
            po1 = po0 + IDX_W'(ph1 - win_reg);
            ph1 = win_reg;
        end
    end

    always_comb begin
        if (state_reg == ST_JRD) begin
            rd_addr = oldest_reg + IDX_W'(held_reg - CNT_W'(1));
        end else begin
            rd_addr = oldest_reg + k_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_PUSH) begin
            pos_mem[push_addr]  <= in_pos_reg;
            quat_mem[push_addr] <= in_quat_reg;
        end
        rd_pos_reg  <= pos_mem[rd_addr];
        rd_quat_reg <= quat_mem[rd_addr];
    end

    // Jump test helpers
    logic [POS_W:0]   jd [3];
    logic             jbig;
    logic [THR_W-1:0] mop;
    logic [61:0]      mprod;

    always_comb begin
        logic signed [POS_W:0] df;
        jbig = 1'b0;
        for (int i = 0; i < 3; i++) begin
            df = $signed({in_pos_reg[i*POS_W+POS_W-1], in_pos_reg[i*POS_W +: POS_W]})
               - $signed({rd_pos_reg[i*POS_W+POS_W-1], rd_pos_reg[i*POS_W +: POS_W]});
            jd[i] = df[POS_W] ? (POS_W+1)'(-df) : (POS_W+1)'(df);
            if (jd[i] > (POS_W+1)'(thr_reg)) begin
                jbig = 1'b1;
            end
        end
        mop   = (mcnt_reg == 2'd3) ? thr_reg : d_reg[mcnt_reg][THR_W-1:0];
        mprod = 62'(mop) * 62'(mop);
    end

    // Walk helpers
    logic signed [33:0] dot;
    always_comb begin
        dot = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]) + 34'(prod_reg[3]);
    end

    // Quaternion norm helpers
    logic [18:0] qa;
    logic [36:0] qa2;
    logic [39:0] qr2;
    logic [33:0] sq_trial;
    logic [16:0] rnd;
    always_comb begin
        qa       = sq_reg[mcnt_reg][19] ? 19'(-sq_reg[mcnt_reg]) : sq_reg[mcnt_reg][18:0];
        qa2      = 37'(qa) * 37'(qa);
        qr2      = {r_reg, (cnt_reg == '0) ? sq2_reg[j_reg][0] : 1'b0};
        sq_trial = res_reg + bit_reg;
        rnd      = 17'((res_reg + 34'd1) >> 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            thr_reg      <= THR_RESET;
            wsize_reg    <= WSIZE_RESET;
            held_reg     <= '0;
            oldest_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    REG_JUMP_THRESHOLD: thr_reg   <= cfg_data[THR_W-1:0];
                    REG_WINDOW_SIZE:    wsize_reg <= cfg_data[WS_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready && state_reg != ST_FIN) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        in_pos_reg  <= s_tdata[3*POS_W-1:0];
                        in_quat_reg <= s_tdata[3*POS_W +: 4*QC_W];
                        win_reg     <= eff_win;
                        jump_reg    <= 1'b0;
                        for (int i = 0; i < 3; i++) ap_reg[i] <= '0;
                        for (int i = 0; i < 4; i++) aq_reg[i] <= '0;
                        if (func_t'(s_tuser) == FUNC_CLEAR) begin
                            held_reg   <= '0;
                            oldest_reg <= '0;
                            state_reg  <= ST_FIN;
                        end else if (held_reg != '0) begin
                            state_reg <= ST_JRD;
                        end else begin
                            state_reg <= ST_PUSH;
                        end
                    end
                end
                ST_JRD: begin
                    state_reg <= ST_JCHK;
                end
                ST_JCHK: begin
                    for (int i = 0; i < 3; i++) d_reg[i] <= jd[i];
                    mcnt_reg <= '0;
                    dsum_reg <= '0;
                    if (jbig) begin
                        jump_reg   <= 1'b1;
                        held_reg   <= '0;
                        oldest_reg <= '0;
                        state_reg  <= ST_PUSH;
                    end else begin
                        state_reg <= ST_JMUL;
                    end
                end
                ST_JMUL: begin
                    mcnt_reg <= mcnt_reg + 2'd1;
                    if (mcnt_reg != 2'd3) begin
                        dsum_reg <= dsum_reg + 64'(mprod);
                    end else begin
                        if (dsum_reg > 64'(mprod)) begin
                            jump_reg   <= 1'b1;
                            held_reg   <= '0;
                            oldest_reg <= '0;
                        end
                        state_reg <= ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    held_reg   <= ph1;
                    oldest_reg <= po1;
                    k_reg      <= '0;
                    for (int i = 0; i < 3; i++) sp_reg[i] <= '0;
                    for (int i = 0; i < 4; i++) sq_reg[i] <= '0;
                    state_reg  <= ST_WRD;
                end
                ST_WRD: begin
                    state_reg <= ST_WLAT;
                end
                ST_WLAT: begin
                    for (int i = 0; i < 4; i++) begin
                        c_reg[i]    <= $signed(rd_quat_reg[i*QC_W +: QC_W]);
                        prod_reg[i] <= ref_reg[i] * $signed(rd_quat_reg[i*QC_W +: QC_W]);
                    end
                    wpos_reg  <= rd_pos_reg;
                    state_reg <= ST_WACC;
                end
                ST_WACC: begin
                    for (int i = 0; i < 3; i++) begin
                        sp_reg[i] <= sp_reg[i] + 36'($signed(wpos_reg[i*POS_W +: POS_W]));
                    end
                    for (int i = 0; i < 4; i++) begin
                        if (k_reg != '0 && dot < 0) begin
                            sq_reg[i] <= sq_reg[i] - 20'(c_reg[i]);
                        end else begin
                            sq_reg[i] <= sq_reg[i] + 20'(c_reg[i]);
                        end
                        if (k_reg == '0) begin
                            ref_reg[i] <= c_reg[i];
                        end
                    end
                    k_reg <= k_reg + CNT_W'(1);
                    if (k_reg + CNT_W'(1) == held_reg) begin
                        cnt_reg   <= '0;
                        state_reg <= ST_PDIV;
                    end else begin
                        state_reg <= ST_WRD;
                    end
                end
                ST_PDIV: begin
                    for (int i = 0; i < 3; i++) begin
                        logic [35:0] pm;
                        logic [4:0]  pr2;
                        pm = sp_reg[i][35] ? 36'(-sp_reg[i]) : 36'(sp_reg[i]);
                        if (cnt_reg == '0) begin
                            psign_reg[i] <= sp_reg[i][35];
                            num_reg[i]   <= pm[34:0] + 35'(held_reg >> 1);
                            rem_reg[i]   <= '0;
                        end else begin
                            pr2 = {rem_reg[i], num_reg[i][34]};
                            if (pr2 >= 5'(held_reg)) begin
                                rem_reg[i] <= 4'(pr2 - 5'(held_reg));
                                num_reg[i] <= {num_reg[i][33:0], 1'b1};
                            end else begin
                                rem_reg[i] <= pr2[3:0];
                                num_reg[i] <= {num_reg[i][33:0], 1'b0};
                            end
                        end
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd36) begin
                        for (int i = 0; i < 3; i++) begin
                            ap_reg[i] <= psign_reg[i] ? POS_W'(-num_reg[i]) : num_reg[i][POS_W-1:0];
                        end
                        mcnt_reg  <= '0;
                        n_reg     <= '0;
                        state_reg <= ST_NSQ;
                    end
                end
                ST_NSQ: begin
                    sq2_reg[mcnt_reg] <= qa2;
                    n_reg    <= n_reg + 39'(qa2);
                    mcnt_reg <= mcnt_reg + 2'd1;
                    if (mcnt_reg == 2'd3) begin
                        if (n_reg + 39'(qa2) == '0) begin
                            state_reg <= ST_FIN;
                        end else begin
                            j_reg     <= '0;
                            cnt_reg   <= '0;
                            quo_reg   <= '0;
                            state_reg <= ST_QDIV;
                        end
                    end else if (mcnt_reg == 2'd0) begin
                        r_reg <= 39'(qa2 >> 1);
                    end
                end
                ST_QDIV: begin
                    if (qr2 >= 40'(n_reg)) begin
                        r_reg   <= 39'(qr2 - 40'(n_reg));
                        quo_reg <= {quo_reg[31:0], 1'b1};
                    end else begin
                        r_reg   <= qr2[38:0];
                        quo_reg <= {quo_reg[31:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd32) begin
                        res_reg   <= '0;
                        bit_reg   <= 34'(1) << 32;
                        state_reg <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (bit_reg == 34'(1) << 32) begin
                        if (34'(quo_reg) >= sq_trial) begin
                            x_reg   <= 34'(quo_reg) - sq_trial;
                            res_reg <= (res_reg >> 1) + bit_reg;
                        end else begin
                            x_reg   <= 34'(quo_reg);
                            res_reg <= res_reg >> 1;
                        end
                    end else if (x_reg >= sq_trial) begin
                        x_reg   <= x_reg - sq_trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    if (bit_reg[0]) begin
                        state_reg <= ST_QOUT;
                    end
                end
                ST_QOUT: begin
                    if (sq_reg[j_reg][19]) begin
                        aq_reg[j_reg] <= QC_W'(-rnd);
                    end else if (rnd > 17'd32767) begin
                        aq_reg[j_reg] <= 16'h7fff;
                    end else begin
                        aq_reg[j_reg] <= rnd[QC_W-1:0];
                    end
                    cnt_reg <= '0;
                    quo_reg <= '0;
                    r_reg   <= 39'(sq2_reg[j_reg + 2'd1] >> 1);
                    j_reg   <= j_reg + 2'd1;
                    if (j_reg == 2'd3) begin
                        state_reg <= ST_FIN;
                    end else begin
                        state_reg <= ST_QDIV;
                    end
                end
                ST_FIN: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {2'b00, aq_reg[3], aq_reg[2], aq_reg[1], aq_reg[0],
                                         ap_reg[2], ap_reg[1], ap_reg[0], jump_reg,
                                         held_reg >= win_reg, held_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `PWA_NEVER(a_held_range, held_reg > CNT_W'(DEPTH), "window count beyond depth")
    `PWA_ASSERT(a_accept_busy, (s_tvalid && s_tready) |=> state_reg != ST_IDLE, "request left block idle")
    `PWA_ASSERT(a_result_src, $rose(m_tvalid_reg) |-> $past(state_reg == ST_FIN), "result not from final step")
    `PWA_ASSERT(a_push_count, (state_reg == ST_PUSH) |=> (held_reg != '0 && held_reg <= win_reg), "push left bad count")

endmodule
